// ===== rtl/arfp_pkg.sv =====
package arfp_pkg;

  localparam int unsigned NumRounds = 21;

  typedef struct packed {
    logic [63:0] in_word5;
    logic [63:0] in_word4;
    logic [63:0] in_word3;
    logic [63:0] in_word2;
    logic [63:0] in_word1;
    logic [63:0] in_word0;
    logic        mode;
  } arfp_in_t;

  typedef struct packed {
    logic [63:0] out_word5;
    logic [63:0] out_word4;
    logic [63:0] out_word3;
    logic [63:0] out_word2;
    logic [63:0] out_word1;
    logic [63:0] out_word0;
  } arfp_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // one aes encryption round, byte i at bits 8i+7:8i
  function automatic logic [127:0] aes_enc(input logic [127:0] blk, input logic [127:0] key);
    logic [127:0] t;
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, al;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        t[8*(row+4*col) +: 8] = SBOX[blk[8*(row+4*((col+row)%4)) +: 8]];
      end
    end
    for (int col = 0; col < 4; col++) begin
      a0 = t[8*(4*col) +: 8];
      a1 = t[8*(4*col+1) +: 8];
      a2 = t[8*(4*col+2) +: 8];
      a3 = t[8*(4*col+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      r[8*(4*col) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
      r[8*(4*col+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      r[8*(4*col+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      r[8*(4*col+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    aes_enc = r ^ key;
  endfunction

endpackage

// ===== rtl/aes_round_feistel_permutation_384_top.sv =====
// simpira v2 (b = 3) 384-bit permutation, forward or inverse per item
// input channel: in_valid_i / in_stall_o carry arfp_in_t (mode, six words)
// output channel: out_valid_o / out_stall_i carry arfp_out_t
// a transfer happens at a clock edge with valid high and stall low
// 21 register stages, one per feistel round (two aes rounds each)
// throughput is one item per cycle when the receiver takes every result
// a stall from the receiver freezes the whole pipeline; empty stages stay
// empty while it is frozen, and in_stall_o is high only when the last stage
// is full and stalled
// reset clears all valid bits; nothing else is held across items
module aes_round_feistel_permutation_384_top import arfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  arfp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output arfp_out_t out_data_o
);
  logic [NumRounds:0]  vld;
  logic [NumRounds:0]  md;
  logic [383:0]        st [NumRounds+1];
  logic                en;

  assign en = !(vld[NumRounds] && out_stall_i);
  assign in_stall_o = !en;

  assign vld[0] = in_valid_i;
  assign md[0]  = in_data_i.mode;
  assign st[0]  = {in_data_i.in_word5, in_data_i.in_word4, in_data_i.in_word3,
                   in_data_i.in_word2, in_data_i.in_word1, in_data_i.in_word0};

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    arfp_round #(.FwdC(g + 1)) u_rnd (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vld[g]), .mode_i(md[g]), .st_i(st[g]),
      .valid_o(vld[g+1]), .mode_o(md[g+1]), .st_o(st[g+1])
    );
  end

  assign out_valid_o = vld[NumRounds];
  assign {out_data_o.out_word5, out_data_o.out_word4, out_data_o.out_word3,
          out_data_o.out_word2, out_data_o.out_word1, out_data_o.out_word0} = st[NumRounds];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> vld[1] == $past(in_valid_i))
    else $error("valid lost at first stage");
endmodule

// ===== rtl/arfp_round.sv =====
// one feistel round per stage: counter c is fixed per stage for each direction
module arfp_round import arfp_pkg::*; #(
  parameter int unsigned FwdC = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic         mode_i,
  input  logic [383:0] st_i,
  output logic         valid_o,
  output logic         mode_o,
  output logic [383:0] st_o
);
  localparam int unsigned InvC = NumRounds + 1 - FwdC;

  function automatic logic [383:0] fround(input logic [383:0] st, input int unsigned c);
    logic [127:0] key;
    logic [127:0] f;
    logic [383:0] o;
    int unsigned dst, src;
    key = '0;
    for (int l = 0; l < 4; l++) begin
      key[32*l +: 8] = 8'((32'h30 - 32'h10 * l) ^ c ^ 32'd3);
    end
    dst = c % 3;
    src = (c + 2) % 3;
    f = aes_enc(aes_enc(st[128*src +: 128], key), '0);
    o = st;
    o[128*dst +: 128] = st[128*dst +: 128] ^ f;
    fround = o;
  endfunction

  logic [383:0] st_d, st_q;
  logic         valid_q, mode_q;

  assign st_d = mode_i ? fround(st_i, InvC) : fround(st_i, FwdC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      mode_q <= mode_i;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign st_o    = st_q;
endmodule
